FILE: hw/rtl/tcce_pkg.sv
// shared types, codes and constants of the text console character engine
// no dependencies; used by scoped names in every module of the block but tcce_queue
package tcce_pkg;

  localparam int COLUMNS_DEFAULT     = 80;
  localparam int ROWS_DEFAULT        = 25;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int MAX_COLUMNS         = 128;
  localparam int MAX_ROWS            = 64;

  // fixed field widths
  localparam int CMD_W        = 2;
  localparam int CHAR_W       = 8;
  localparam int ROW_FIELD_W  = 5;
  localparam int COL_FIELD_W  = 7;
  localparam int CELL_W       = 16;
  localparam int POS_W        = 11;
  localparam int ATTR_W       = 8;
  localparam int TOP_W        = 5;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam int ADDR_FIELD_W = $clog2(MAX_COLUMNS * MAX_ROWS);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT,
    CMD_READ,
    CMD_CLEAR,
    CMD_MOVE
  } cmd_e;

  typedef enum logic {
    REG_ATTRIBUTE,
    REG_SCROLL_TOP
  } reg_idx_e;

  // control bytes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LEFT      = 8'h11;
  localparam logic [CHAR_W-1:0] CH_RIGHT     = 8'h12;
  localparam logic [CHAR_W-1:0] CH_UP        = 8'h13;
  localparam logic [CHAR_W-1:0] CH_DOWN      = 8'h14;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;

  localparam logic [CELL_W-1:0] RESET_CELL       = 16'h0F20;
  localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE  = 8'h0F;
  localparam logic [TOP_W-1:0]  RESET_SCROLL_TOP = 5'd10;

  // operation after classification
  typedef enum logic [3:0] {
    OP_PRINT,
    OP_BACKSPACE,
    OP_LEFT,
    OP_RIGHT,
    OP_UP,
    OP_DOWN,
    OP_CR,
    OP_LF,
    OP_TAB,
    OP_NOP,
    OP_READ,
    OP_CLEAR,
    OP_MOVE
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [CHAR_W-1:0]       char_code;
    logic [ROW_FIELD_W-1:0]  row;
    logic [COL_FIELD_W-1:0]  column;
    logic [ADDR_FIELD_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic [ATTR_W-1:0] attribute;
    logic [TOP_W-1:0]  scroll_top;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0]      cell_value;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic [POS_W-1:0]       cursor_position;
  } result_t;

endpackage

FILE: hw/rtl/text_console_char_engine_unit.sv
// top level of the text console character engine: config registers and wiring
// depends on tcce_pkg, tcce_front, tcce_queue and tcce_back
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------------
//  command   | in        | push / full                  | command, char_code, row, column
//  result    | out       | pop / empty                  | cell_value, cursor_row/column/pos
//  config    | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// sequence: move, put and ignored bytes pass the exec and done states in the back end,
//   backspace adds a write state and read cell a read wait state; a scroll and a clear
//   add the one-cell-per-cycle sweep over the cell store and a drain state
// reset: after rst_ni rises the store is swept to 0x0F20, one cell per cycle;
//   full stays high until the sweep ends, config writes still land
// stalls: a command queue decouples push from the back end, and the result register
//   lets the back end finish one item while the previous result waits for pop
module text_console_char_engine_unit #(
  parameter int COLUMNS     = tcce_pkg::COLUMNS_DEFAULT,
  parameter int ROWS        = tcce_pkg::ROWS_DEFAULT,
  parameter int QUEUE_DEPTH = tcce_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command transfer
  input  logic                                push,
  output logic                                full,
  input  logic [tcce_pkg::CMD_W-1:0]          command_i,
  input  logic [tcce_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tcce_pkg::ROW_FIELD_W-1:0]    row_i,
  input  logic [tcce_pkg::COL_FIELD_W-1:0]    column_i,
  // result transfer
  output logic                                empty,
  input  logic                                pop,
  output logic [tcce_pkg::CELL_W-1:0]         cell_value_o,
  output logic [tcce_pkg::ROW_FIELD_W-1:0]    cursor_row_o,
  output logic [tcce_pkg::COL_FIELD_W-1:0]    cursor_column_o,
  output logic [tcce_pkg::POS_W-1:0]          cursor_position_o,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcce_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tcce_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tcce_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int ENTRY_W = $bits(tcce_pkg::entry_t);

  tcce_pkg::cfg_t     cfg_q;
  tcce_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;

  tcce_pkg::entry_t   front_entry, head_entry;
  logic [ENTRY_W-1:0] head_bits;
  logic               q_push, q_pop, q_full, q_empty;
  logic               busy_init;
  logic               res_valid;
  tcce_pkg::result_t  res;

  // register port: pready always high, byte address 4 * index
  assign pready  = 1'b1;
  assign reg_idx = tcce_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      tcce_pkg::REG_ATTRIBUTE:
        prdata = tcce_pkg::APB_DATA_W'(cfg_q.attribute);
      tcce_pkg::REG_SCROLL_TOP:
        prdata = tcce_pkg::APB_DATA_W'(cfg_q.scroll_top);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attribute  <= tcce_pkg::RESET_ATTRIBUTE;
      cfg_q.scroll_top <= tcce_pkg::RESET_SCROLL_TOP;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tcce_pkg::REG_ATTRIBUTE:  cfg_q.attribute  <= pwdata[tcce_pkg::ATTR_W-1:0];
        tcce_pkg::REG_SCROLL_TOP: cfg_q.scroll_top <= pwdata[tcce_pkg::TOP_W-1:0];
      endcase
    end
  end

  // front end classifies the command as it is accepted
  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .q_full_i    (q_full),
    .busy_i      (busy_init),
    .q_push_o    (q_push),
    .entry_o     (front_entry)
  );

  // decoupling queue of classified operations
  tcce_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (front_entry),
    .pop_i     (q_pop),
    .rd_data_o (head_bits),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  assign head_entry = tcce_pkg::entry_t'(head_bits);

  // back end owns the cursor, the cell store and the result register
  tcce_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .busy_init_o (busy_init),
    .res_valid_o (res_valid),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  // result side
  assign empty             = ~res_valid;
  assign cell_value_o      = res.cell_value;
  assign cursor_row_o      = res.cursor_row;
  assign cursor_column_o   = res.cursor_column;
  assign cursor_position_o = res.cursor_position;

endmodule

FILE: hw/rtl/tcce_front.sv
// front end: accepts commands and classifies them into operations
// depends on tcce_pkg
module tcce_front #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [tcce_pkg::CMD_W-1:0]          command_i,
  input  logic [tcce_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tcce_pkg::ROW_FIELD_W-1:0]    row_i,
  input  logic [tcce_pkg::COL_FIELD_W-1:0]    column_i,
  input  logic                                q_full_i,
  input  logic                                busy_i,
  output logic                                q_push_o,
  output tcce_pkg::entry_t                    entry_o
);

  logic in_range;

  assign full_o   = q_full_i | busy_i;
  assign q_push_o = push_i & ~full_o;
  assign in_range = (32'(row_i) < 32'(ROWS)) && (32'(column_i) < 32'(COLUMNS));

  always_comb begin
    entry_o.char_code = char_code_i;
    entry_o.op        = tcce_pkg::OP_NOP;
    // saturated coordinates for move cursor
    entry_o.row    = (32'(row_i) > 32'(ROWS - 1)) ?
                     tcce_pkg::ROW_FIELD_W'(ROWS - 1) : row_i;
    entry_o.column = (32'(column_i) > 32'(COLUMNS - 1)) ?
                     tcce_pkg::COL_FIELD_W'(COLUMNS - 1) : column_i;
    entry_o.addr   = tcce_pkg::ADDR_FIELD_W'(32'(row_i) * COLUMNS + 32'(column_i));
    unique case (tcce_pkg::cmd_e'(command_i))
      tcce_pkg::CMD_PUT: begin
        unique case (char_code_i)
          tcce_pkg::CH_BACKSPACE: entry_o.op = tcce_pkg::OP_BACKSPACE;
          tcce_pkg::CH_LEFT:      entry_o.op = tcce_pkg::OP_LEFT;
          tcce_pkg::CH_RIGHT:     entry_o.op = tcce_pkg::OP_RIGHT;
          tcce_pkg::CH_UP:        entry_o.op = tcce_pkg::OP_UP;
          tcce_pkg::CH_DOWN:      entry_o.op = tcce_pkg::OP_DOWN;
          tcce_pkg::CH_CR:        entry_o.op = tcce_pkg::OP_CR;
          tcce_pkg::CH_LF:        entry_o.op = tcce_pkg::OP_LF;
          tcce_pkg::CH_TAB:       entry_o.op = tcce_pkg::OP_TAB;
          default: begin
            if (char_code_i >= tcce_pkg::CH_PRINT_LO && char_code_i <= tcce_pkg::CH_PRINT_HI)
              entry_o.op = tcce_pkg::OP_PRINT;
            else
              entry_o.op = tcce_pkg::OP_NOP;
          end
        endcase
      end
      // out of range read returns zero and changes nothing
      tcce_pkg::CMD_READ:  entry_o.op = in_range ? tcce_pkg::OP_READ : tcce_pkg::OP_NOP;
      tcce_pkg::CMD_CLEAR: entry_o.op = tcce_pkg::OP_CLEAR;
      tcce_pkg::CMD_MOVE:  entry_o.op = tcce_pkg::OP_MOVE;
    endcase
  end

endmodule

FILE: hw/rtl/tcce_queue.sv
// small first-word-fall-through queue between front and back end
// depends on no other file
module tcce_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o    = count_q == CNT_W'(DEPTH);
  assign empty_o   = count_q == '0;
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;
  assign rd_data_o = data_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) data_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tcce_back.sv
// back end: cursor logic, cell store, scroll/clear sweep and result register
// depends on tcce_pkg
module tcce_back #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcce_pkg::entry_t  head_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  tcce_pkg::cfg_t    cfg_i,
  output logic              busy_init_o,
  output logic              res_valid_o,
  input  logic              res_pop_i,
  output tcce_pkg::result_t res_o
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_ADDR = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ROW_W:0]    ROWS_L        = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]    COLS_L        = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W-1:0]  MAX_ROW       = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  MAX_COL       = COL_W'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BS_WRITE,
    ST_READ_WAIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e                      state_q;
  logic                        init_q;
  tcce_pkg::op_e               op_q;
  logic [tcce_pkg::CHAR_W-1:0] ch_q;
  logic [ROW_W-1:0]            row_q, cur_y_q;
  logic [COL_W-1:0]            col_q, cur_x_q;
  logic [ADDR_W-1:0]           addr_q;
  logic [tcce_pkg::CELL_W-1:0] value_q;
  logic [ADDR_W-1:0]           sw_addr_q, sw_lim_q, wp_addr_q;
  logic                        wp_valid_q, wp_copy_q;
  logic                        res_valid_q;
  tcce_pkg::result_t           res_q;

  logic [tcce_pkg::CELL_W-1:0] mem_q [CELLS];
  logic [tcce_pkg::CELL_W-1:0] rd_data_q;

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_wa, mem_ra;
  logic [tcce_pkg::CELL_W-1:0] mem_wd, blank_cell;
  logic [ADDR_W-1:0]           cur_addr, top_addr, sw_src;
  logic [ROW_W-1:0]            top_row;
  logic                        sw_copy;
  logic [COL_W:0]              nx, nx_w;
  logic [ROW_W:0]              ny, ny_w;
  logic                        scroll;
  logic                        res_load;

  assign cur_addr   = ADDR_W'(32'(cur_y_q) * COLUMNS) + ADDR_W'(cur_x_q);
  assign top_row    = (32'(cfg_i.scroll_top) > 32'(ROWS - 1)) ?
                      MAX_ROW : ROW_W'(cfg_i.scroll_top);
  assign top_addr   = ADDR_W'(32'(top_row) * COLUMNS);
  assign blank_cell = init_q ? tcce_pkg::RESET_CELL : {cfg_i.attribute, tcce_pkg::CH_BLANK};
  assign sw_copy    = sw_addr_q < sw_lim_q;
  assign sw_src     = ADDR_W'(32'(sw_addr_q) + COLUMNS);

  // next cursor for put character operations
  always_comb begin
    nx = {1'b0, cur_x_q};
    ny = {1'b0, cur_y_q};
    unique case (op_q)
      tcce_pkg::OP_PRINT, tcce_pkg::OP_RIGHT: nx = {1'b0, cur_x_q} + 1'b1;
      tcce_pkg::OP_BACKSPACE, tcce_pkg::OP_LEFT: begin
        if (cur_x_q != '0) begin
          nx = {1'b0, cur_x_q} - 1'b1;
        end else if (cur_y_q != '0) begin
          nx = {1'b0, MAX_COL};
          ny = {1'b0, cur_y_q} - 1'b1;
        end
      end
      tcce_pkg::OP_UP:   if (cur_y_q != '0) ny = {1'b0, cur_y_q} - 1'b1;
      tcce_pkg::OP_DOWN: ny = {1'b0, cur_y_q} + 1'b1;
      tcce_pkg::OP_CR:   nx = '0;
      tcce_pkg::OP_LF: begin
        nx = '0;
        ny = {1'b0, cur_y_q} + 1'b1;
      end
      tcce_pkg::OP_TAB: nx = {1'b0, cur_x_q} + (COL_W + 1)'(4);
      default: ;
    endcase
    // column overflow wraps onto the next row
    if (nx >= COLS_L) begin
      nx_w = nx - COLS_L;
      ny_w = ny + 1'b1;
    end else begin
      nx_w = nx;
      ny_w = ny;
    end
    scroll = ny_w >= ROWS_L;
  end

  // one write port shared by the sweep, print and backspace
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_addr;
    mem_wd = blank_cell;
    if (wp_valid_q) begin
      mem_we = 1'b1;
      mem_wa = wp_addr_q;
      mem_wd = wp_copy_q ? rd_data_q : blank_cell;
    end else if (state_q == ST_EXEC && op_q == tcce_pkg::OP_PRINT) begin
      mem_we = 1'b1;
      mem_wd = {cfg_i.attribute, ch_q};
    end else if (state_q == ST_BS_WRITE) begin
      mem_we = 1'b1;
    end
    mem_ra = (state_q == ST_SWEEP && sw_copy) ? sw_src : addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_data_q <= mem_q[mem_ra];
  end

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign res_load    = (state_q == ST_DONE) && (!res_valid_q || res_pop_i);
  assign busy_init_o = init_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      init_q      <= 1'b1;
      op_q        <= tcce_pkg::OP_NOP;
      ch_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      value_q     <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      sw_addr_q   <= '0;
      sw_lim_q    <= '0;
      wp_addr_q   <= '0;
      wp_valid_q  <= 1'b0;
      wp_copy_q   <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      wp_valid_q <= 1'b0;
      if (res_load) begin
        res_valid_q                 <= 1'b1;
        res_q.cell_value            <= value_q;
        res_q.cursor_row            <= tcce_pkg::ROW_FIELD_W'(cur_y_q);
        res_q.cursor_column         <= tcce_pkg::COL_FIELD_W'(cur_x_q);
        res_q.cursor_position       <= tcce_pkg::POS_W'(cur_addr);
      end else if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            op_q    <= head_i.op;
            ch_q    <= head_i.char_code;
            row_q   <= ROW_W'(head_i.row);
            col_q   <= COL_W'(head_i.column);
            addr_q  <= ADDR_W'(head_i.addr);
            value_q <= '0;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (op_q)
            tcce_pkg::OP_READ: state_q <= ST_READ_WAIT;
            tcce_pkg::OP_CLEAR: begin
              cur_x_q   <= '0;
              cur_y_q   <= top_row;
              sw_addr_q <= '0;
              sw_lim_q  <= '0;
              state_q   <= ST_SWEEP;
            end
            tcce_pkg::OP_MOVE: begin
              cur_x_q <= col_q;
              cur_y_q <= row_q;
              state_q <= ST_DONE;
            end
            tcce_pkg::OP_BACKSPACE: begin
              cur_x_q <= nx_w[COL_W-1:0];
              cur_y_q <= ny_w[ROW_W-1:0];
              state_q <= ST_BS_WRITE;
            end
            default: begin
              if (scroll) begin
                cur_x_q   <= '0;
                cur_y_q   <= MAX_ROW;
                sw_addr_q <= top_addr;
                sw_lim_q  <= LAST_ROW_ADDR;
                state_q   <= ST_SWEEP;
              end else begin
                cur_x_q <= nx_w[COL_W-1:0];
                cur_y_q <= ny_w[ROW_W-1:0];
                state_q <= ST_DONE;
              end
            end
          endcase
        end
        ST_BS_WRITE: state_q <= ST_DONE;
        ST_READ_WAIT: begin
          value_q <= rd_data_q;
          state_q <= ST_DONE;
        end
        ST_SWEEP: begin
          // read the row below now while copying, write the destination next cycle
          wp_valid_q <= 1'b1;
          wp_addr_q  <= sw_addr_q;
          wp_copy_q  <= sw_copy;
          if (sw_addr_q == LAST_ADDR) state_q   <= ST_DRAIN;
          else                        sw_addr_q <= sw_addr_q + 1'b1;
        end
        ST_DRAIN: begin
          if (init_q) begin
            init_q  <= 1'b0;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: if (res_load) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tcce_checker.sv
// port-level checks of the text console character engine, bound to the top level
// depends on tcce_pkg and text_console_char_engine_unit
module tcce_checker #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             push,
  input logic                             full,
  input logic                             pop,
  input logic                             empty,
  input logic [tcce_pkg::CELL_W-1:0]      cell_value_o,
  input logic [tcce_pkg::ROW_FIELD_W-1:0] cursor_row_o,
  input logic [tcce_pkg::COL_FIELD_W-1:0] cursor_column_o,
  input logic [tcce_pkg::POS_W-1:0]       cursor_position_o
);

  // position check only where no field masking happens
  localparam bit CHECK_POS = (ROWS <= 32) && (ROWS * COLUMNS <= 2048);

  logic [7:0] outstanding_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      unique case ({push && !full, pop && !empty})
        2'b10:   outstanding_q <= outstanding_q + 1'b1;
        2'b01:   outstanding_q <= outstanding_q - 1'b1;
        default: outstanding_q <= outstanding_q;
      endcase
    end
  end

  // no result without an accepted command behind it
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> outstanding_q != 8'd0)
    else $error("result shown with no command outstanding");

  // linear position agrees with row and column
  a_position_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CHECK_POS && !empty) |->
      32'(cursor_position_o) == 32'(cursor_row_o) * COLUMNS + 32'(cursor_column_o))
    else $error("cursor position does not match row and column");

  // cursor stays on the screen
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CHECK_POS && !empty) |->
      (32'(cursor_column_o) < 32'(COLUMNS)) && (32'(cursor_row_o) < 32'(ROWS)))
    else $error("cursor outside the screen");

  // a waiting result holds until popped
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(cell_value_o) && $stable(cursor_position_o)))
    else $error("waiting result changed before pop");

endmodule

bind text_console_char_engine_unit tcce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcce_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .push              (push),
  .full              (full),
  .pop               (pop),
  .empty             (empty),
  .cell_value_o      (cell_value_o),
  .cursor_row_o      (cursor_row_o),
  .cursor_column_o   (cursor_column_o),
  .cursor_position_o (cursor_position_o)
);
